FILE: rtl/core/cwp_pkg.sv
// shared types, constants and small tables of the cube wireframe projector
// no dependencies; imported by cwp_front, cwp_back and the core top
`default_nettype none

package cwp_pkg;

	localparam int VERTEX_COUNT = 8;
	localparam int VTX_W        = 3;
	localparam int BANK_W       = 2;
	localparam int ADDR_W       = BANK_W + VTX_W;
	localparam int RAM_DEPTH    = 1 << ADDR_W;
	localparam int COORD_W      = 13;
	localparam int VWORD_W      = 2 * COORD_W;
	localparam int EDGE_W       = 4;
	localparam int POS_W        = 19;
	localparam int NUM_W        = 26;
	localparam int DEN_W        = 19;

	// phase scale 683565276 split in two 16 bit halves
	localparam logic signed [15:0] PHASE_K_HI = 16'sd10430;
	localparam logic [15:0]        PHASE_K_LO = 16'd24796;

	localparam logic signed [19:0] CORDIC_X0    = 20'sd79595;
	localparam int                 CORDIC_STEPS = 14;
	localparam logic signed [19:0] DEPTH_Q8     = 20'sd51200;
	localparam logic signed [27:0] SAT_LO       = -28'sd4096;
	localparam logic signed [27:0] SAT_HI       = 28'sd4095;

	localparam logic [1:0] CFG_MID_X     = 2'd0;
	localparam logic [1:0] CFG_MID_Y     = 2'd1;
	localparam logic [1:0] CFG_CUBE_SIZE = 2'd2;

	localparam logic       SHAPE_LINE   = 1'b0;
	localparam logic       SHAPE_CIRCLE = 1'b1;
	localparam logic [1:0] COLOR_BLACK  = 2'd0;
	localparam logic [1:0] COLOR_WHITE  = 2'd1;
	localparam logic [1:0] COLOR_YELLOW = 2'd2;
	localparam logic [2:0] RADIUS_NONE  = 3'd0;
	localparam logic [2:0] RADIUS_DRAW  = 3'd3;
	localparam logic [2:0] RADIUS_ERASE = 3'd4;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [VWORD_W-1:0]  data;
	} cwp_vwr_t;

	function automatic logic [13:0] atan_step(input logic [3:0] i);
		logic [13:0] t;
		case (i)
			4'd0:    t = 14'd8192;
			4'd1:    t = 14'd4836;
			4'd2:    t = 14'd2555;
			4'd3:    t = 14'd1297;
			4'd4:    t = 14'd651;
			4'd5:    t = 14'd326;
			4'd6:    t = 14'd163;
			4'd7:    t = 14'd81;
			4'd8:    t = 14'd41;
			4'd9:    t = 14'd20;
			4'd10:   t = 14'd10;
			4'd11:   t = 14'd5;
			4'd12:   t = 14'd3;
			4'd13:   t = 14'd1;
			default: t = 14'd0;
		endcase
		return t;
	endfunction

	// negative corner sign per axis, bits {x, y, z}
	function automatic logic [2:0] corner_neg(input logic [VTX_W-1:0] v);
		logic [2:0] s;
		case (v)
			3'd0:    s = 3'b111;
			3'd1:    s = 3'b011;
			3'd2:    s = 3'b010;
			3'd3:    s = 3'b110;
			3'd4:    s = 3'b101;
			3'd5:    s = 3'b001;
			3'd6:    s = 3'b000;
			default: s = 3'b100;
		endcase
		return s;
	endfunction

	function automatic logic [VTX_W-1:0] edge_a(input logic [EDGE_W-1:0] e);
		logic [VTX_W-1:0] v;
		case (e)
			4'd8:    v = 3'd0;
			4'd9:    v = 3'd1;
			4'd10:   v = 3'd2;
			4'd11:   v = 3'd3;
			default: v = e[VTX_W-1:0];
		endcase
		return v;
	endfunction

	function automatic logic [VTX_W-1:0] edge_b(input logic [EDGE_W-1:0] e);
		logic [VTX_W-1:0] v;
		case (e)
			4'd0:    v = 3'd1;
			4'd1:    v = 3'd2;
			4'd2:    v = 3'd3;
			4'd3:    v = 3'd0;
			4'd4:    v = 3'd5;
			4'd5:    v = 3'd6;
			4'd6:    v = 3'd7;
			4'd7:    v = 3'd4;
			4'd8:    v = 3'd4;
			4'd9:    v = 3'd5;
			4'd10:   v = 3'd6;
			default: v = 3'd7;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cwp_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module cwp_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/core/cwp_div.sv
// unsigned restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module cwp_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/cwp_queue.sv
// two entry frame queue between front and back, carries the erase flag
// depends on nothing; the front never pushes into a full queue
`default_nettype none

module cwp_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic din,
	input  wire logic pop,
	output logic      valid,
	output logic      dout
);

	logic       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	assign valid = (cnt_q != 2'd0);
	assign dout  = ent_q[rp_q];

endmodule

`default_nettype wire

FILE: rtl/core/cwp_front.sv
// front: takes the angle beat, runs sine/cosine, rotation and projection
// depends on cwp_pkg and cwp_div; writes vertices to the ram and frames to the queue
`default_nettype none

module cwp_front
	import cwp_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] pitch_angle,
	input  wire logic signed [15:0] yaw_angle,
	input  wire logic [9:0]         mid_x,
	input  wire logic [9:0]         mid_y,
	input  wire logic [7:0]         cube_size,
	input  wire logic               cfg_hit,
	input  wire logic               frame_done,
	output cwp_vwr_t                vwr,
	output logic                    q_push,
	output logic                    q_erase
);

	typedef enum logic [8:0] {
		F_IDLE = 9'b000000001,
		F_PH1  = 9'b000000010,
		F_PH2  = 9'b000000100,
		F_ROT  = 9'b000001000,
		F_TRIG = 9'b000010000,
		F_MUL  = 9'b000100000,
		F_ACC  = 9'b001000000,
		F_DIV  = 9'b010000000,
		F_WR   = 9'b100000000
	} fstate_t;

	localparam logic [2:0] MIX_X1 = 3'd0;
	localparam logic [2:0] MIX_Y1 = 3'd1;
	localparam logic [2:0] MIX_X2 = 3'd2;
	localparam logic [2:0] MIX_Z2 = 3'd3;
	localparam logic [2:0] MIX_Y3 = 3'd4;
	localparam logic [2:0] MIX_Z3 = 3'd5;

	localparam logic [1:0] ANG_ROLL  = 2'd0;
	localparam logic [1:0] ANG_PITCH = 2'd1;
	localparam logic [1:0] ANG_YAW   = 2'd2;

	fstate_t state_q;

	logic signed [15:0] ang_q [3];
	logic [1:0]         ai_q;
	logic               first_q;
	logic               erase_q;
	logic [1:0]         inflight_q;
	logic [BANK_W-1:0]  wbank_q;

	logic signed [31:0] pp_hi_s1;
	logic signed [32:0] pp_lo_s1;

	logic signed [19:0] rx_q;
	logic signed [19:0] ry_q;
	logic signed [17:0] rz_q;
	logic [3:0]         it_q;
	logic               neg_q;

	logic signed [15:0] sin_r_q, cos_r_q, sin_p_q, cos_p_q, sin_y_q, cos_y_q;

	logic [VTX_W-1:0]       vi_q;
	logic [2:0]             ms_q;
	logic signed [POS_W-1:0] x1_q, y1_q, x2_q, z2_q, y3_q;
	logic signed [34:0]     pa_s1, pb_s1;
	logic                   qx_neg_q, qy_neg_q;

	logic signed [15:0]      ang;
	logic [47:0]             prod;
	logic [15:0]             p16;
	logic signed [17:0]      p18;
	logic signed [17:0]      pz;
	logic                    pneg;
	logic signed [19:0]      dx, dy;
	logic signed [17:0]      at;
	logic signed [15:0]      tc, ts;
	logic [14:0]             half;
	logic [2:0]              cneg;
	logic signed [POS_W-1:0] cxn, cyn, czn;
	logic signed [POS_W-1:0] op_a, op_b;
	logic signed [15:0]      co_a, co_b;
	logic signed [35:0]      msum;
	logic signed [POS_W-1:0] mres;
	logic signed [19:0]      dsum;
	logic [DEN_W-1:0]        den;
	logic [26:0]             nx, ny;
	logic [NUM_W-1:0]        nx_mag, ny_mag;
	logic                    div_start;
	logic                    div_x_busy, div_y_busy;
	logic [NUM_W-1:0]        quo_x, quo_y;
	logic [COORD_W-1:0]      scr_x, scr_y;
	logic                    accept, slot_ok, wr_fire, last_vtx;

	function automatic logic signed [15:0] trig_out(input logic signed [19:0] v,
		input logic neg);
		logic signed [19:0] r;
		logic signed [15:0] c;
		r = (v + 20'sd2) >>> 2;
		if (r > 20'sd32767) begin
			c = 16'sd32767;
		end else if (r < -20'sd32767) begin
			c = -16'sd32767;
		end else begin
			c = r[15:0];
		end
		return neg ? -c : c;
	endfunction

	// truncated quotient with sign, plus centre, saturated to the signed 13 bit coordinate range
	function automatic logic [COORD_W-1:0] to_screen(input logic [NUM_W-1:0] q,
		input logic neg, input logic [9:0] centre);
		logic signed [27:0] s;
		logic signed [27:0] t;
		s = $signed({2'b00, q});
		if (neg) begin
			s = -s;
		end
		t = s + $signed({18'd0, centre});
		if (t < SAT_LO) begin
			t = SAT_LO;
		end else if (t > SAT_HI) begin
			t = SAT_HI;
		end
		return t[COORD_W-1:0];
	endfunction

	assign accept = push && (state_q == F_IDLE);
	assign full   = (state_q != F_IDLE);

	always_comb begin
		ang  = ang_q[ai_q];
		prod = {pp_hi_s1, 16'h0000} + {{15{pp_lo_s1[32]}}, pp_lo_s1};
		p16  = prod[ANGLE_FRAC_BITS+16 +: 16];
		p18  = $signed({{2{p16[15]}}, p16});
		pz   = p18;
		pneg = 1'b0;
		if (p18 > 18'sd16384) begin
			pz   = p18 - 18'sd32768;
			pneg = 1'b1;
		end else if (p18 < -18'sd16384) begin
			pz   = p18 + 18'sd32768;
			pneg = 1'b1;
		end
		dx = ry_q >>> it_q;
		dy = rx_q >>> it_q;
		at = $signed({4'b0000, atan_step(it_q)});
		tc = trig_out(rx_q, neg_q);
		ts = trig_out(ry_q, neg_q);

		half = {cube_size, 7'b0000000};
		cneg = corner_neg(vi_q);
		cxn  = cneg[2] ? -$signed({4'b0000, half}) : $signed({4'b0000, half});
		cyn  = cneg[1] ? -$signed({4'b0000, half}) : $signed({4'b0000, half});
		czn  = cneg[0] ? -$signed({4'b0000, half}) : $signed({4'b0000, half});

		case (ms_q)
			MIX_X1: begin
				op_a = cxn; co_a = cos_y_q; op_b = cyn; co_b = -sin_y_q;
			end
			MIX_Y1: begin
				op_a = cxn; co_a = sin_y_q; op_b = cyn; co_b = cos_y_q;
			end
			MIX_X2: begin
				op_a = x1_q; co_a = cos_p_q; op_b = czn; co_b = sin_p_q;
			end
			MIX_Z2: begin
				op_a = x1_q; co_a = -sin_p_q; op_b = czn; co_b = cos_p_q;
			end
			MIX_Y3: begin
				op_a = y1_q; co_a = cos_r_q; op_b = z2_q; co_b = -sin_r_q;
			end
			default: begin
				op_a = y1_q; co_a = sin_r_q; op_b = z2_q; co_b = cos_r_q;
			end
		endcase

		msum = 36'(pa_s1) + 36'(pb_s1) + 36'sd16384;
		mres = msum[POS_W+14:15];

		// depth and numerators are ready in the cycle that makes z3
		dsum = DEPTH_Q8 + 20'(mres);
		den  = (dsum < 20'sd1) ? DEN_W'(1) : dsum[DEN_W-1:0];
		nx   = {{8{x2_q[POS_W-1]}}, x2_q} * 27'd200;
		ny   = {{8{y3_q[POS_W-1]}}, y3_q} * 27'd200;
		nx_mag = nx[26] ? NUM_W'(-nx) : nx[NUM_W-1:0];
		ny_mag = ny[26] ? NUM_W'(-ny) : ny[NUM_W-1:0];
		div_start = (state_q == F_ACC) && (ms_q == MIX_Z3);

		scr_x = to_screen(quo_x, qx_neg_q, mid_x);
		scr_y = to_screen(quo_y, qy_neg_q, mid_y);

		slot_ok  = (inflight_q < 2'd2);
		wr_fire  = (state_q == F_WR) && slot_ok;
		last_vtx = (vi_q == VTX_W'(VERTEX_COUNT - 1));
	end

	cwp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nx_mag),
		.den    (den),
		.busy   (div_x_busy),
		.quo    (quo_x)
	);

	cwp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ny_mag),
		.den    (den),
		.busy   (div_y_busy),
		.quo    (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			first_q    <= 1'b1;
			inflight_q <= 2'd0;
			wbank_q    <= '0;
			ai_q       <= '0;
			it_q       <= '0;
			ms_q       <= '0;
			vi_q       <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, q_push} - {1'b0, frame_done};
			if (cfg_hit) begin
				first_q <= 1'b1;
			end else if (accept) begin
				first_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (push) begin
						ai_q    <= ANG_ROLL;
						state_q <= F_PH1;
					end
				end
				F_PH1: begin
					state_q <= F_PH2;
				end
				F_PH2: begin
					it_q    <= '0;
					state_q <= F_ROT;
				end
				F_ROT: begin
					it_q <= it_q + 1'b1;
					if (it_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= F_TRIG;
					end
				end
				F_TRIG: begin
					if (ai_q == ANG_YAW) begin
						vi_q    <= '0;
						ms_q    <= MIX_X1;
						state_q <= F_MUL;
					end else begin
						ai_q    <= ai_q + 1'b1;
						state_q <= F_PH1;
					end
				end
				F_MUL: begin
					state_q <= F_ACC;
				end
				F_ACC: begin
					if (ms_q == MIX_Z3) begin
						state_q <= F_DIV;
					end else begin
						ms_q    <= ms_q + 1'b1;
						state_q <= F_MUL;
					end
				end
				F_DIV: begin
					if (!div_x_busy && !div_y_busy) begin
						state_q <= F_WR;
					end
				end
				F_WR: begin
					if (slot_ok) begin
						if (last_vtx) begin
							wbank_q <= wbank_q + 1'b1;
							state_q <= F_IDLE;
						end else begin
							vi_q    <= vi_q + 1'b1;
							ms_q    <= MIX_X1;
							state_q <= F_MUL;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q[ANG_ROLL]  <= roll_angle;
			ang_q[ANG_PITCH] <= pitch_angle;
			ang_q[ANG_YAW]   <= yaw_angle;
			erase_q          <= ~first_q;
		end
		if (state_q == F_PH1) begin
			pp_hi_s1 <= ang * PHASE_K_HI;
			pp_lo_s1 <= ang * $signed({1'b0, PHASE_K_LO});
		end
		if (state_q == F_PH2) begin
			rx_q  <= CORDIC_X0;
			ry_q  <= '0;
			rz_q  <= pz;
			neg_q <= pneg;
		end
		if (state_q == F_ROT) begin
			if (!rz_q[17]) begin
				rx_q <= rx_q - dx;
				ry_q <= ry_q + dy;
				rz_q <= rz_q - at;
			end else begin
				rx_q <= rx_q + dx;
				ry_q <= ry_q - dy;
				rz_q <= rz_q + at;
			end
		end
		if (state_q == F_TRIG) begin
			case (ai_q)
				ANG_ROLL: begin
					sin_r_q <= ts;
					cos_r_q <= tc;
				end
				ANG_PITCH: begin
					sin_p_q <= ts;
					cos_p_q <= tc;
				end
				default: begin
					sin_y_q <= ts;
					cos_y_q <= tc;
				end
			endcase
		end
		if (state_q == F_MUL) begin
			pa_s1 <= op_a * co_a;
			pb_s1 <= op_b * co_b;
		end
		if (state_q == F_ACC) begin
			case (ms_q)
				MIX_X1:  x1_q <= mres;
				MIX_Y1:  y1_q <= mres;
				MIX_X2:  x2_q <= mres;
				MIX_Z2:  z2_q <= mres;
				MIX_Y3:  y3_q <= mres;
				default: ;
			endcase
		end
		if (div_start) begin
			qx_neg_q <= nx[26];
			qy_neg_q <= ny[26];
		end
	end

	always_comb begin
		vwr.en   = wr_fire;
		vwr.addr = {wbank_q, vi_q};
		vwr.data = {scr_x, scr_y};
		q_push   = wr_fire && last_vtx;
		q_erase  = erase_q;
	end

endmodule

`default_nettype wire

FILE: rtl/core/cwp_back.sv
// back: walks the draw commands of one frame and drives the result register
// depends on cwp_pkg; reads previous and new vertices from the ram
`default_nettype none

module cwp_back
	import cwp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire logic                q_erase,
	output logic                     q_pop,
	output logic      [ADDR_W-1:0]   rd_addr_a,
	output logic      [ADDR_W-1:0]   rd_addr_b,
	input  wire logic [VWORD_W-1:0]  rd_data_a,
	input  wire logic [VWORD_W-1:0]  rd_data_b,
	output logic                     frame_done,
	output logic                     empty,
	input  wire logic                pop,
	output logic                     shape_kind,
	output logic      [1:0]          paint_color,
	output logic signed [12:0]       start_x,
	output logic signed [12:0]       start_y,
	output logic signed [12:0]       end_x,
	output logic signed [12:0]       end_y,
	output logic      [2:0]          circle_radius,
	output logic                     last_command
);

	localparam logic [5:0] ERASE_LINE_END  = 6'd12;
	localparam logic [5:0] ERASE_DOT_END   = 6'd20;
	localparam logic [5:0] DRAW_LINE_END   = 6'd32;
	localparam logic [5:0] LAST_CMD        = 6'd39;

	logic              active_q;
	logic [5:0]        k_q;
	logic [BANK_W-1:0] bank_q;
	logic              rd_s1;
	logic              kind_s1;
	logic [1:0]        color_s1;
	logic [2:0]        radius_s1;
	logic              last_s1;
	logic              out_valid_q;

	logic              c_kind;
	logic [1:0]        c_color;
	logic [2:0]        c_radius;
	logic [BANK_W-1:0] c_bank;
	logic [EDGE_W-1:0] c_edge;
	logic [VTX_W-1:0]  c_vtx;
	logic [5:0]        k_off;
	logic              issue;

	always_comb begin
		if (k_q < ERASE_LINE_END) begin
			c_kind = SHAPE_LINE;   c_color = COLOR_BLACK;  c_radius = RADIUS_NONE;
			k_off  = k_q;          c_bank  = bank_q - 1'b1;
		end else if (k_q < ERASE_DOT_END) begin
			c_kind = SHAPE_CIRCLE; c_color = COLOR_BLACK;  c_radius = RADIUS_ERASE;
			k_off  = k_q - ERASE_LINE_END; c_bank = bank_q - 1'b1;
		end else if (k_q < DRAW_LINE_END) begin
			c_kind = SHAPE_LINE;   c_color = COLOR_WHITE;  c_radius = RADIUS_NONE;
			k_off  = k_q - ERASE_DOT_END;  c_bank = bank_q;
		end else begin
			c_kind = SHAPE_CIRCLE; c_color = COLOR_YELLOW; c_radius = RADIUS_DRAW;
			k_off  = k_q - DRAW_LINE_END;  c_bank = bank_q;
		end
		c_edge = k_off[EDGE_W-1:0];
		c_vtx  = k_off[VTX_W-1:0];
		if (c_kind == SHAPE_LINE) begin
			rd_addr_a = {c_bank, edge_a(c_edge)};
			rd_addr_b = {c_bank, edge_b(c_edge)};
		end else begin
			rd_addr_a = {c_bank, c_vtx};
			rd_addr_b = {c_bank, c_vtx};
		end
		// the result register is free next cycle when empty or being taken now
		issue      = active_q && !rd_s1 && (!out_valid_q || pop);
		frame_done = issue && (k_q == LAST_CMD);
		q_pop      = !active_q && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			k_q         <= '0;
			bank_q      <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (frame_done) begin
				active_q <= 1'b0;
				bank_q   <= bank_q + 1'b1;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end else if (q_pop) begin
				active_q <= 1'b1;
				k_q      <= q_erase ? 6'd0 : ERASE_DOT_END;
			end
			if (rd_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1   <= c_kind;
			color_s1  <= c_color;
			radius_s1 <= c_radius;
			last_s1   <= (k_q == LAST_CMD);
		end
		if (rd_s1) begin
			shape_kind    <= kind_s1;
			paint_color   <= color_s1;
			circle_radius <= radius_s1;
			last_command  <= last_s1;
			start_x       <= rd_data_a[VWORD_W-1:COORD_W];
			start_y       <= rd_data_a[COORD_W-1:0];
			if (kind_s1 == SHAPE_LINE) begin
				end_x <= rd_data_b[VWORD_W-1:COORD_W];
				end_y <= rd_data_b[COORD_W-1:0];
			end else begin
				end_x <= '0;
				end_y <= '0;
			end
		end
	end

	assign empty = ~out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/cube_wireframe_projector_core.sv
// Rotating wireframe cube projector. One input beat carries roll, pitch and
// yaw (signed, ANGLE_FRAC_BITS fraction bits); it yields 20 draw commands on
// the first frame and 40 afterwards (12 erase lines and 8 erase circles from
// the stored vertices, then 12 white edges and 8 yellow circles).
// Input: push/full; a beat is taken when push is high and full is low.
// Results: empty/pop; the oldest command sits on the ports while empty is low
// and leaves on pop. last_command marks the final command of a frame.
// Config: cfg_valid/cfg_ready (always ready), cfg_index 0..2 selects screen x
// and y of the cube middle and cube_size; any of these writes restarts
// first-frame mode. Write config only while idle.
// Flow: the front takes no new beat until the last vertex of the current frame
// is written: the accept, then per angle phase and the 14 step cordic, then per
// vertex a rotation by multiply-accumulate, a bit-serial divide and a write.
// The back issues a command only when no vertex read is in flight and the
// result register is free or being taken.
// Reset: config returns to 120/120/80, first-frame mode is set, queues empty.
// A stalled receiver holds the result register; the front runs ahead and
// stalls at a vertex write once two frames are queued or still being drawn.
// Depends on cwp_pkg, cwp_ram, cwp_div, cwp_queue, cwp_front, cwp_back.
`default_nettype none

module cube_wireframe_projector_core
	import cwp_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] pitch_angle,
	input  wire logic signed [15:0] yaw_angle,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [9:0]         cfg_data,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    shape_kind,
	output logic      [1:0]         paint_color,
	output logic signed [12:0]      start_x,
	output logic signed [12:0]      start_y,
	output logic signed [12:0]      end_x,
	output logic signed [12:0]      end_y,
	output logic      [2:0]         circle_radius,
	output logic                    last_command
);

	logic [9:0]   mid_x_q;
	logic [9:0]   mid_y_q;
	logic [7:0]   cube_size_q;
	logic         cfg_hit;
	logic         frame_done;
	cwp_vwr_t     vwr;
	logic         q_push, q_erase_in, q_valid, q_erase_out, q_pop;
	logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
	logic [VWORD_W-1:0] rd_data_a, rd_data_b;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_MID_X ||
		cfg_index == CFG_MID_Y || cfg_index == CFG_CUBE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_x_q     <= 10'd120;
			mid_y_q     <= 10'd120;
			cube_size_q <= 8'd80;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MID_X:     mid_x_q     <= cfg_data;
				CFG_MID_Y:     mid_y_q     <= cfg_data;
				CFG_CUBE_SIZE: cube_size_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cwp_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.mid_x       (mid_x_q),
		.mid_y       (mid_y_q),
		.cube_size   (cube_size_q),
		.cfg_hit     (cfg_hit),
		.frame_done  (frame_done),
		.vwr         (vwr),
		.q_push      (q_push),
		.q_erase     (q_erase_in)
	);

	cwp_ram #(.WIDTH(VWORD_W), .DEPTH(RAM_DEPTH)) u_vtx_ram (
		.clk       (clk),
		.wr_en     (vwr.en),
		.wr_addr   (vwr.addr),
		.wr_data   (vwr.data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	cwp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_erase_in),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_erase_out)
	);

	cwp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_erase       (q_erase_out),
		.q_pop         (q_pop),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.rd_data_a     (rd_data_a),
		.rd_data_b     (rd_data_b),
		.frame_done    (frame_done),
		.empty         (empty),
		.pop           (pop),
		.shape_kind    (shape_kind),
		.paint_color   (paint_color),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.circle_radius (circle_radius),
		.last_command  (last_command)
	);

endmodule

`default_nettype wire
